### hw/rtl/stack_syntax_tree_builder_macros.svh
// Assertion macros for the syntax tree builder.
// Used by the top level; no other dependencies.
`ifndef STACK_SYNTAX_TREE_BUILDER_MACROS_SVH
`define STACK_SYNTAX_TREE_BUILDER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SSTB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define SSTB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define SSTB_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SSTB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hw/rtl/sstb_pkg.sv
// Types and codes shared by the syntax tree builder.
// No dependencies.
`default_nettype none
package sstb_pkg;
	localparam int NODE_BITS = 12;
	localparam int KBITS = 8;
	localparam int TBITS = 20;

	typedef enum logic [2:0] {
		EV_BEGIN = 3'd0, EV_ADD = 3'd1, EV_END = 3'd2, EV_READ_NODE = 3'd3,
		EV_READ_ENTRY = 3'd4, EV_BAD5 = 3'd5, EV_BAD6 = 3'd6, EV_BAD7 = 3'd7
	} event_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_FULL = 2'd1, ST_NO_OPEN = 2'd2, ST_RANGE = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  syn_kind;
		logic [19:0] token_index;
		logic [11:0] node_id;
		logic [11:0] list_index;
	} in_item_t;

	typedef struct packed {
		logic [11:0] result_node;
		logic [7:0]  result_kind;
		logic [19:0] first_token;
		logic [19:0] token_count;
		logic [12:0] parent_node;
		logic [12:0] first_child;
		logic [10:0] child_count;
		logic [11:0] child_entry;
		logic [1:0]  status;
	} out_item_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DECIDE, S_RDREC, S_WALK_RD, S_WALK_WR, S_FINISH, S_EMIT, S_OUT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_CAPTURE, OP_DECIDE, OP_READ_REC, OP_WALK_RD, OP_WALK_WR,
		OP_FINISH, OP_EMIT
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic walk_needed;
		logic walk_last;
	} stat_t;
endpackage
`default_nettype wire

### hw/rtl/sstb_ctrl.sv
// Controller state machine for the syntax tree builder.
// Depends on sstb_pkg.
`default_nettype none
module sstb_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  wire logic          out_stall,
	input  wire sstb_pkg::stat_t stat,
	output sstb_pkg::cmd_t     cmd
);
	import sstb_pkg::*;
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd.op = OP_NONE;
		in_stall = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.op = OP_CAPTURE;
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.op = OP_DECIDE;
				state_d = S_RDREC;
			end
			S_RDREC: begin
				cmd.op = OP_READ_REC;
				if (stat.walk_needed) state_d = S_WALK_RD;
				else state_d = S_FINISH;
			end
			S_WALK_RD: begin
				cmd.op = OP_WALK_RD;
				state_d = S_WALK_WR;
			end
			S_WALK_WR: begin
				cmd.op = OP_WALK_WR;
				if (stat.walk_last) state_d = S_FINISH;
				else state_d = S_WALK_RD;
			end
			S_FINISH: begin
				cmd.op = OP_FINISH;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				cmd.op = OP_EMIT;
				state_d = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

### hw/rtl/sstb_dpath.sv
// Datapath of the syntax tree builder: node record memories, stacks, child list.
// Depends on sstb_pkg.
`default_nettype none
module sstb_dpath #(
	parameter int MAX_NODES = 4096,
	parameter int PENDING_DEPTH = 1024,
	parameter int NEST_DEPTH = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire sstb_pkg::in_item_t in_data,
	input  wire sstb_pkg::cmd_t     cmd,
	output sstb_pkg::stat_t         stat,
	output sstb_pkg::out_item_t     out_data
);
	import sstb_pkg::*;
	localparam int NB = $clog2(MAX_NODES);
	localparam int PB = $clog2(PENDING_DEPTH);
	localparam int MB = $clog2(NEST_DEPTH);

	logic [KBITS-1:0] kind_mem [MAX_NODES];
	logic [TBITS-1:0] ftok_mem [MAX_NODES];
	logic [TBITS-1:0] tcnt_mem [MAX_NODES];
	logic [12:0]      par_mem [MAX_NODES];
	logic [12:0]      fch_mem [MAX_NODES];
	logic [10:0]      cc_mem [MAX_NODES];
	logic [11:0]      pend_mem [PENDING_DEPTH];
	logic [PB:0]      mark_mem [NEST_DEPTH];
	logic [11:0]      list_mem [MAX_NODES];

	logic [NB:0] node_count_q, list_len_q;
	logic [PB:0] pend_depth_q;
	logic [MB:0] mark_depth_q;

	in_item_t  it_q;
	status_t   st_q;
	logic      do_q;
	logic [PB:0] mark_q, walk_q;
	logic [PB:0] mark_top_q;
	logic [NB:0] fc_q;
	logic [11:0] child_q;
	logic [11:0] entry_q;
	logic [KBITS-1:0] rk_q;
	logic [TBITS-1:0] rf_q, rt_q;
	logic [12:0] rp_q, rfc_q;
	logic [10:0] rc_q;
	out_item_t out_q;

	logic [PB:0] mark_rd;
	logic [PB:0] mark_eff;
	logic [PB:0] cnt;
	logic        id_ok;

	assign id_ok = {1'b0, it_q.node_id} < 13'(node_count_q);
	assign mark_rd = (mark_depth_q != '0) ? mark_top_q : '0;
	assign mark_eff = (mark_rd > pend_depth_q) ? pend_depth_q : mark_rd;
	assign cnt = pend_depth_q - mark_eff;
	assign stat.walk_needed = do_q && event_t'(it_q.kind) == EV_END && walk_q != pend_depth_q;
	assign stat.walk_last = (walk_q + 1'b1) == pend_depth_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= '0;
			list_len_q <= '0;
			pend_depth_q <= '0;
			mark_depth_q <= '0;
			do_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_CAPTURE: begin
					it_q <= in_data;
					mark_top_q <= mark_mem[MB'(mark_depth_q - 1'b1)];
				end
				OP_DECIDE: begin
					do_q <= 1'b0;
					st_q <= ST_OK;
					walk_q <= mark_eff;
					mark_q <= mark_eff;
					case (event_t'(it_q.kind))
						EV_BEGIN: begin
							if (node_count_q >= (NB+1)'(MAX_NODES)
								|| mark_depth_q >= (MB+1)'(NEST_DEPTH)) st_q <= ST_FULL;
							else begin
								do_q <= 1'b1;
								node_count_q <= node_count_q + 1'b1;
								kind_mem[NB'(node_count_q)] <= it_q.syn_kind;
								ftok_mem[NB'(node_count_q)] <= it_q.token_index;
								tcnt_mem[NB'(node_count_q)] <= '0;
								par_mem[NB'(node_count_q)] <= 13'(MAX_NODES);
								fch_mem[NB'(node_count_q)] <= '0;
								cc_mem[NB'(node_count_q)] <= '0;
								mark_mem[MB'(mark_depth_q)] <= pend_depth_q;
								mark_depth_q <= mark_depth_q + 1'b1;
								it_q.node_id <= 12'(node_count_q);
							end
						end
						EV_ADD: begin
							if (!id_ok) st_q <= ST_RANGE;
							else if (pend_depth_q >= (PB+1)'(PENDING_DEPTH)) st_q <= ST_FULL;
							else begin
								pend_mem[PB'(pend_depth_q)] <= it_q.node_id;
								pend_depth_q <= pend_depth_q + 1'b1;
							end
						end
						EV_END: begin
							if (mark_depth_q == '0) st_q <= ST_NO_OPEN;
							else if (!id_ok) st_q <= ST_RANGE;
							else if (32'(list_len_q) + 32'(cnt) > 32'(MAX_NODES))
								st_q <= ST_FULL;
							else begin
								do_q <= 1'b1;
								mark_depth_q <= mark_depth_q - 1'b1;
								fc_q <= list_len_q;
							end
						end
						EV_READ_NODE: begin
							if (!id_ok) st_q <= ST_RANGE;
							else do_q <= 1'b1;
						end
						EV_READ_ENTRY: begin
							if ({1'b0, it_q.list_index} >= 13'(list_len_q)) st_q <= ST_RANGE;
							else entry_q <= list_mem[NB'(it_q.list_index)];
						end
						default: st_q <= ST_RANGE;
					endcase
				end
				OP_READ_REC: begin
					rf_q <= ftok_mem[NB'(it_q.node_id)];
				end
				OP_WALK_RD: child_q <= pend_mem[PB'(walk_q)];
				OP_WALK_WR: begin
					if (32'(child_q) < MAX_NODES) par_mem[NB'(child_q)] <= 13'(it_q.node_id);
					list_mem[NB'(list_len_q)] <= child_q;
					list_len_q <= list_len_q + 1'b1;
					walk_q <= walk_q + 1'b1;
				end
				OP_FINISH: begin
					if (do_q && event_t'(it_q.kind) == EV_END) begin
						pend_depth_q <= mark_q;
						fch_mem[NB'(it_q.node_id)] <= 13'(fc_q);
						cc_mem[NB'(it_q.node_id)] <= 11'(pend_depth_q - mark_q);
						tcnt_mem[NB'(it_q.node_id)] <= (it_q.token_index > rf_q) ?
							it_q.token_index - rf_q : '0;
					end
				end
				OP_EMIT: begin
					rk_q <= kind_mem[NB'(it_q.node_id)];
					rt_q <= tcnt_mem[NB'(it_q.node_id)];
					rp_q <= par_mem[NB'(it_q.node_id)];
					rfc_q <= fch_mem[NB'(it_q.node_id)];
					rc_q <= cc_mem[NB'(it_q.node_id)];
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		out_q = '0;
		out_q.status = st_q;
		if (st_q == ST_OK) begin
			case (event_t'(it_q.kind))
				EV_ADD: out_q.result_node = it_q.node_id;
				EV_READ_ENTRY: out_q.child_entry = entry_q;
				default: begin
					out_q.result_node = it_q.node_id;
					out_q.result_kind = rk_q;
					out_q.first_token = rf_q;
					out_q.token_count = rt_q;
					out_q.parent_node = rp_q;
					out_q.first_child = rfc_q;
					out_q.child_count = rc_q;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

### hw/rtl/stack_syntax_tree_builder.sv
// Top level of the syntax tree builder: controller plus datapath.
// Depends on sstb_pkg, sstb_ctrl, sstb_dpath and the macros header.
//
// Usage: parser events enter on in_valid/in_stall with payload in_data; one
// result per event leaves on out_valid/out_stall with payload out_data.
// One event is in flight at a time. Each event passes through the decide,
// record-read, finish and emit states before its result is valid; an end with
// pending children also walks them between record-read and finish, with one
// pending-stack read and one child-list write per child. After the result
// transfers the block returns to idle, where it takes the next event.
// The result holds in its register while out_stall is high and the block takes
// no new event until that result transfers.
// Reset clears the counters and stack depths at once; the record memories are
// written on node allocation, so no clearing pass runs.
`default_nettype none
`include "stack_syntax_tree_builder_macros.svh"
module stack_syntax_tree_builder #(
	parameter int MAX_NODES = 4096,
	parameter int PENDING_DEPTH = 1024,
	parameter int NEST_DEPTH = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire sstb_pkg::in_item_t in_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output sstb_pkg::out_item_t     out_data
);
	import sstb_pkg::*;
	cmd_t cmd;
	stat_t stat;

	sstb_ctrl u_ctrl (.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
		.stat, .cmd);
	sstb_dpath #(.MAX_NODES(MAX_NODES), .PENDING_DEPTH(PENDING_DEPTH),
		.NEST_DEPTH(NEST_DEPTH)) u_dpath (.clk, .arst_n, .in_data, .cmd, .stat, .out_data);

	`SSTB_ASSERT_IMPL(a_no_take_busy, clk, arst_n, out_valid, in_stall)
	`SSTB_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data))
	`SSTB_ASSERT_NEXT(a_take_no_out, clk, arst_n, in_valid && !in_stall, !out_valid)
endmodule
`default_nettype wire
